@@ rtl/prq_pkg.sv @@
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants of the priority request queue: operation and
// status codes, priority limits, and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int PRIO_BITS = 7;
   localparam logic [PRIO_BITS-1:0] PRIORITY_LIMIT = 7'd100;

   // operation codes of a request transaction
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_TOP    = 2'd1,
      OP_CLEAN  = 2'd2
   } op_type;

   // status codes of a response transaction
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;     // capture the request
      logic refuse;     // mark the insert as refused
      logic ins_start;  // start the insert walk from the tail
      logic ins_step;   // evaluate one entry of the insert walk
      logic ins_put;    // write the new entry and count it
      logic cmp_start;  // start the compaction walk from the head
      logic cmp_step;   // evaluate one entry of the compaction walk
      logic respond;    // load the response register
   } ctl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic op_insert;
      logic op_top;
      logic op_clean;
      logic queue_full;
      logic queue_empty;
      logic ins_shift;  // entry under test moves one slot toward the tail
      logic ins_first;  // entry under test is the head slot
      logic cmp_last;   // entry under test is the last held entry
      logic rsp_free;   // response register can take a new transaction
   } dp_stat_type;

endpackage

@@ rtl/prq_channels.sv @@
// ----------------------------------------------------------------------------
// prq channels
// Valid/ready channel interfaces of the queue: request, response and the
// configuration write port.
// ----------------------------------------------------------------------------
interface prq_req_if #(
   parameter int TIME_BITS = 32,
   parameter int TAG_BITS  = 16
);
   import prq_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [1:0]           operation;
   logic [PRIO_BITS-1:0] node_priority;
   logic [TIME_BITS-1:0] request_timeout;
   logic [TAG_BITS-1:0]  request_tag;
   logic [TIME_BITS-1:0] time_now;

   modport source (output valid, operation, node_priority, request_timeout,
                   request_tag, time_now, input ready);
   modport sink   (input valid, operation, node_priority, request_timeout,
                   request_tag, time_now, output ready);
endinterface

interface prq_rsp_if #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_BITS   = 32,
   parameter int TAG_BITS    = 16
);
   import prq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [TAG_BITS-1:0]  top_tag;
   logic [PRIO_BITS-1:0] top_priority;
   logic [TIME_BITS-1:0] top_timeout;
   logic [CW-1:0]        entry_count;

   modport source (output valid, status, top_tag, top_priority, top_timeout,
                   entry_count, input ready);
   modport sink   (input valid, status, top_tag, top_priority, top_timeout,
                   entry_count, output ready);
endinterface

interface prq_csr_if;
   import prq_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [PRIO_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/prq_ram.sv @@
// ----------------------------------------------------------------------------
// prq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/prq_datapath.sv @@
// ----------------------------------------------------------------------------
// prq_datapath
// Entry store, walk counters, captured request, head capture and the
// response register of the priority request queue.
// ----------------------------------------------------------------------------
module prq_datapath #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_BITS   = 32,
   parameter int TAG_BITS    = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  prq_pkg::ctl_cmd_type          cmd,
   output prq_pkg::dp_stat_type          stat,
   // configuration write
   input  logic                          csr_valid,
   input  logic [prq_pkg::PRIO_BITS-1:0] csr_data,
   // request payload
   input  logic [1:0]                    req_operation,
   input  logic [prq_pkg::PRIO_BITS-1:0] req_node_priority,
   input  logic [TIME_BITS-1:0]          req_request_timeout,
   input  logic [TAG_BITS-1:0]           req_request_tag,
   input  logic [TIME_BITS-1:0]          req_time_now,
   // response
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [TAG_BITS-1:0]           rsp_top_tag,
   output logic [prq_pkg::PRIO_BITS-1:0] rsp_top_priority,
   output logic [TIME_BITS-1:0]          rsp_top_timeout,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] rsp_entry_count
);
   import prq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = PRIO_BITS + TIME_BITS + TAG_BITS;

   // configuration and captured request
   logic [PRIO_BITS-1:0] default_prio_ff;
   logic [1:0]           op_ff;
   logic [PRIO_BITS-1:0] prio_ff;
   logic [TIME_BITS-1:0] timeout_ff;
   logic [TAG_BITS-1:0]  tag_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic                 refused_ff;

   // queue state and walk counters
   logic [CW-1:0]        occ_ff;
   logic [AW-1:0]        k_ff;
   logic [CW-1:0]        r_ff;
   logic [CW-1:0]        w_ff;

   // head capture
   logic                 head_found_ff;
   logic [PRIO_BITS-1:0] head_prio_ff;
   logic [TIME_BITS-1:0] head_time_ff;
   logic [TAG_BITS-1:0]  head_tag_ff;

   // response register
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [TAG_BITS-1:0]  rsp_tag_ff;
   logic [PRIO_BITS-1:0] rsp_prio_ff;
   logic [TIME_BITS-1:0] rsp_time_ff;
   logic [CW-1:0]        rsp_count_ff;

   // store ports
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [EW-1:0]        wr_data;
   logic [AW-1:0]        rd_addr;
   logic [EW-1:0]        rd_data;

   logic [PRIO_BITS-1:0] d_prio;
   logic [TIME_BITS-1:0] d_time;
   logic [TAG_BITS-1:0]  d_tag;
   logic [PRIO_BITS-1:0] prio_in;
   logic [CW-1:0]        occ_m1;
   logic                 ins_shift;
   logic                 keep;
   logic                 op_top;

   prq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // unpack the entry read last cycle
   assign d_prio = rd_data[EW-1 -: PRIO_BITS];
   assign d_time = rd_data[TAG_BITS +: TIME_BITS];
   assign d_tag  = rd_data[TAG_BITS-1:0];

   // resolve out-of-range priority to the clamped default
   always_comb begin
      prio_in = req_node_priority;
      if (req_node_priority > PRIORITY_LIMIT) begin
         prio_in = (default_prio_ff > PRIORITY_LIMIT) ? PRIORITY_LIMIT : default_prio_ff;
      end
   end

   assign op_top    = (op_ff == OP_TOP);
   assign occ_m1    = occ_ff - CW'(1);
   assign ins_shift = (d_prio <= prio_ff);
   // top drops expired entries only ahead of the first survivor
   assign keep      = !((d_time < now_ff) && ((op_ff == OP_CLEAN) || (w_ff == '0)));

   // drive store read and write ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = k_ff;
      wr_data = rd_data;
      rd_addr = '0;
      if (cmd.ins_start) begin
         rd_addr = occ_m1[AW-1:0];
      end
      if (cmd.ins_step) begin
         rd_addr = k_ff - AW'(1) - AW'(1);
         if (ins_shift) begin
            wr_en = 1'b1;
         end
      end
      if (cmd.ins_put) begin
         wr_en   = 1'b1;
         wr_data = {prio_ff, timeout_ff, tag_ff};
      end
      if (cmd.cmp_step) begin
         rd_addr = r_ff[AW-1:0];
         if (keep) begin
            wr_en   = 1'b1;
            wr_addr = w_ff[AW-1:0];
         end
      end
   end

   // status to the controller
   always_comb begin
      stat.op_insert   = (op_ff == OP_INSERT);
      stat.op_top      = op_top;
      stat.op_clean    = (op_ff == OP_CLEAN);
      stat.queue_full  = (occ_ff >= CW'(QUEUE_DEPTH));
      stat.queue_empty = (occ_ff == '0);
      stat.ins_shift   = ins_shift;
      stat.ins_first   = (k_ff == AW'(1));
      stat.cmp_last    = (r_ff == occ_ff);
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         default_prio_ff <= '0;
         occ_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            default_prio_ff <= csr_data;
         end
         if (cmd.ins_put) begin
            occ_ff <= occ_ff + CW'(1);
         end
         if (cmd.cmp_step && stat.cmp_last) begin
            occ_ff <= w_ff + CW'(keep);
         end
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture, walk counters, head capture and response payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff         <= req_operation;
         prio_ff       <= prio_in;
         timeout_ff    <= req_request_timeout;
         tag_ff        <= req_request_tag;
         now_ff        <= req_time_now;
         refused_ff    <= 1'b0;
         head_found_ff <= 1'b0;
      end
      if (cmd.refuse) begin
         refused_ff <= 1'b1;
      end
      if (cmd.ins_start) begin
         k_ff <= occ_ff[AW-1:0];
      end
      if (cmd.ins_step && ins_shift) begin
         k_ff <= k_ff - AW'(1);
      end
      if (cmd.cmp_start) begin
         r_ff <= CW'(1);
         w_ff <= '0;
      end
      if (cmd.cmp_step) begin
         r_ff <= r_ff + CW'(1);
         if (keep) begin
            w_ff <= w_ff + CW'(1);
            if (w_ff == '0) begin
               head_found_ff <= 1'b1;
               head_prio_ff  <= d_prio;
               head_time_ff  <= d_time;
               head_tag_ff   <= d_tag;
            end
         end
      end
      if (cmd.respond) begin
         rsp_count_ff <= occ_ff;
         if (refused_ff) begin
            rsp_status_ff <= STATUS_FULL;
         end else if (op_top && !head_found_ff) begin
            rsp_status_ff <= STATUS_EMPTY;
         end else begin
            rsp_status_ff <= STATUS_OK;
         end
         if (op_top && head_found_ff) begin
            rsp_tag_ff  <= head_tag_ff;
            rsp_prio_ff <= head_prio_ff;
            rsp_time_ff <= head_time_ff;
         end else begin
            rsp_tag_ff  <= '0;
            rsp_prio_ff <= '0;
            rsp_time_ff <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_top_tag      = rsp_tag_ff;
   assign rsp_top_priority = rsp_prio_ff;
   assign rsp_top_timeout  = rsp_time_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

@@ rtl/prq_ctrl.sv @@
// ----------------------------------------------------------------------------
// prq_ctrl
// Controller of the priority request queue: accepts a request, runs the
// insert or compaction walk and hands the result to the response register.
// ----------------------------------------------------------------------------
module prq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  prq_pkg::dp_stat_type stat,
   output prq_pkg::ctl_cmd_type cmd
);
   import prq_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DISPATCH = 6'b000010,
      ST_INS_WALK = 6'b000100,
      ST_INS_PUT  = 6'b001000,
      ST_CMP_WALK = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (stat.op_insert) begin
               if (stat.queue_full) begin
                  cmd.refuse = 1'b1;
                  state_in   = ST_DONE;
               end else begin
                  cmd.ins_start = 1'b1;
                  state_in      = stat.queue_empty ? ST_INS_PUT : ST_INS_WALK;
               end
            end else if (stat.op_top || stat.op_clean) begin
               if (stat.queue_empty) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.cmp_start = 1'b1;
                  state_in      = ST_CMP_WALK;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_INS_WALK: begin
            cmd.ins_step = 1'b1;
            if (!stat.ins_shift || stat.ins_first) begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: begin
            cmd.ins_put = 1'b1;
            state_in    = ST_DONE;
         end
         ST_CMP_WALK: begin
            cmd.cmp_step = 1'b1;
            if (stat.cmp_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/priority_request_queue_expiry_core.sv @@
// ----------------------------------------------------------------------------
// priority_request_queue_expiry_core
// Bounded request queue kept in priority order, with timeout expiry.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan carries one operation per transaction: insert, top (drop expired
//  head entries, then report the head) or clean (drop every expired entry).
//  rsp_chan returns exactly one transaction per request with status, head
//  fields and the entry count after the operation.
//  csr_chan writes default_priority and is always ready; the user must write
//  it only while no request is in flight, as the block does not enforce it.
//  Timing: one request at a time. An insert walks from the tail, moving one
//  entry per cycle through the single write port of the entry RAM. Top and
//  clean run the compaction walk, reading and rewriting one entry per cycle.
//  A refused insert, an empty queue or an unused code skips the walk.
//  Reset empties the queue and clears default_priority; the entry RAM needs
//  no clearing since only held entries are read.
//  A stalled response holds in its output register; the next request is
//  accepted meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
module priority_request_queue_expiry_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_BITS   = 32,
   parameter int TAG_BITS    = 16
) (
   input logic        clock,
   input logic        reset,
   prq_req_if.sink    req_chan,
   prq_rsp_if.source  rsp_chan,
   prq_csr_if.sink    csr_chan
);
   import prq_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   // configuration writes are taken at once
   assign csr_chan.ready = 1'b1;

   prq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   prq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_BITS   (TIME_BITS),
      .TAG_BITS    (TAG_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_valid           (csr_chan.valid),
      .csr_data            (csr_chan.data),
      .req_operation       (req_chan.operation),
      .req_node_priority   (req_chan.node_priority),
      .req_request_timeout (req_chan.request_timeout),
      .req_request_tag     (req_chan.request_tag),
      .req_time_now        (req_chan.time_now),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_status          (rsp_chan.status),
      .rsp_top_tag         (rsp_chan.top_tag),
      .rsp_top_priority    (rsp_chan.top_priority),
      .rsp_top_timeout     (rsp_chan.top_timeout),
      .rsp_entry_count     (rsp_chan.entry_count)
   );

endmodule

@@ verif/tb_priority_request_queue_expiry_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_request_queue_expiry_core
// Checks the priority request queue against its own predictor of the sorted
// queue. Directed requests cover the empty, full, equal-time and default
// priority cases, then phases of random insert/top/clean traffic run with
// a rising time base under several default_priority settings. Both channel
// sides idle in random bursts, and one long response hold-off fills the
// block so that it stalls its request input.
// ----------------------------------------------------------------------------
module tb_priority_request_queue_expiry_core;
   import prq_pkg::*;

   localparam int DEPTH = 16;
   localparam int PHASE_ITEMS = 180;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES = 400;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  op;
      logic [6:0]  prio;
      logic [31:0] tmo;
      logic [15:0] tag;
      logic [31:0] now;
   } request_type;

   typedef struct {
      logic [1:0]  status;
      logic [15:0] tag;
      logic [6:0]  prio;
      logic [31:0] tmo;
      logic [4:0]  count;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   prq_req_if req_chan ();
   prq_rsp_if rsp_chan ();
   prq_csr_if csr_chan ();

   priority_request_queue_expiry_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #4 clock = ~clock;

   // mirror of the queue contents
   logic [6:0]  q_prio [DEPTH];
   logic [31:0] q_tmo [DEPTH];
   logic [15:0] q_tag [DEPTH];
   int          q_count = 0;
   logic [6:0]  dflt_prio = '0;

   request_type  pending_reqs [$];
   response_type expected_rsps [$];
   request_type  cur_req;
   bit        req_taken = 0;
   int        req_gap = 0;
   int        rsp_gap = 0;
   bit        quiet = 0;
   bit        hold_request = 0;
   int        hold_left = 0;
   bit        rsp_hold = 0;
   logic [31:0] sim_now = '0;

   int errors = 0;
   int n_insert = 0, n_top = 0, n_clean = 0, n_unused = 0;
   int n_full = 0, n_empty = 0, n_settings = 0;

   // remove one entry and close the gap
   function automatic void drop_entry(int pos);
      for (int i = pos; i + 1 < q_count; i++) begin
         q_prio[i] = q_prio[i+1];
         q_tmo[i]  = q_tmo[i+1];
         q_tag[i]  = q_tag[i+1];
      end
      q_count--;
   endfunction

   // apply one request to the mirror and return the response it causes
   function automatic response_type apply_request(request_type r);
      response_type rs;
      logic [6:0] p;
      int pos;
      int i;
      rs = '{status: STATUS_OK, tag: '0, prio: '0, tmo: '0, count: '0};
      case (r.op)
         OP_INSERT: begin
            n_insert++;
            p = r.prio;
            if (p > PRIORITY_LIMIT)
               p = (dflt_prio > PRIORITY_LIMIT) ? PRIORITY_LIMIT : dflt_prio;
            if (q_count >= DEPTH) begin
               rs.status = STATUS_FULL;
               n_full++;
            end else begin
               pos = q_count;
               for (i = 0; i < q_count; i++) begin
                  if (q_prio[i] <= p) begin
                     pos = i;
                     break;
                  end
               end
               for (i = q_count; i > pos; i--) begin
                  q_prio[i] = q_prio[i-1];
                  q_tmo[i]  = q_tmo[i-1];
                  q_tag[i]  = q_tag[i-1];
               end
               q_prio[pos] = p;
               q_tmo[pos]  = r.tmo;
               q_tag[pos]  = r.tag;
               q_count++;
            end
         end
         OP_TOP: begin
            n_top++;
            while (q_count > 0 && q_tmo[0] < r.now)
               drop_entry(0);
            if (q_count == 0) begin
               rs.status = STATUS_EMPTY;
               n_empty++;
            end else begin
               rs.tag  = q_tag[0];
               rs.prio = q_prio[0];
               rs.tmo  = q_tmo[0];
            end
         end
         OP_CLEAN: begin
            n_clean++;
            i = 0;
            while (i < q_count) begin
               if (q_tmo[i] < r.now)
                  drop_entry(i);
               else
                  i++;
            end
         end
         default: n_unused++;
      endcase
      rs.count = q_count[4:0];
      return rs;
   endfunction

   task automatic add_item(input logic [1:0] op, input logic [6:0] prio,
                           input logic [31:0] tmo, input logic [15:0] tag,
                           input logic [31:0] now);
      request_type r;
      r = '{op: op, prio: prio, tmo: tmo, tag: tag, now: now};
      pending_reqs.push_back(r);
   endtask

   // mostly well-formed traffic on an advancing time base, some noise
   task automatic add_random_items(input int n, input int span);
      int roll;
      logic [1:0] op;
      logic [6:0] prio;
      for (int k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            add_item(2'($urandom), 7'($urandom), $urandom, 16'($urandom), $urandom);
         end else begin
            if ($urandom_range(0, 99) < 3)
               sim_now += $urandom_range(0, 100000);
            else
               sim_now += $urandom_range(0, 16);
            if (roll < 55)
               op = OP_INSERT;
            else if (roll < 80)
               op = OP_TOP;
            else if (roll < 95)
               op = OP_CLEAN;
            else
               op = OP_UNUSED;
            prio = ($urandom_range(0, 9) < 2) ? 7'($urandom_range(101, 127))
                                              : 7'($urandom_range(0, 100));
            add_item(op, prio, sim_now + $urandom_range(0, span), 16'($urandom),
                     sim_now);
         end
      end
   endtask

   // write default_priority through the configuration channel
   task automatic write_default(input logic [6:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      dflt_prio = value;
      n_settings++;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // wait until every request is answered and the block has settled
   task automatic wait_drained;
      @(posedge clock);
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_chan.valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h",
                  $time, name, want, got);
      end
   endtask

   // hold inputs at known values from the start
   initial begin
      req_chan.valid           = 1'b0;
      req_chan.operation       = '0;
      req_chan.node_priority   = '0;
      req_chan.request_timeout = '0;
      req_chan.request_tag     = '0;
      req_chan.time_now        = '0;
      rsp_chan.ready           = 1'b0;
      csr_chan.valid           = 1'b0;
      csr_chan.data            = '0;
   end

   // record request transactions and predict their responses
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         expected_rsps.push_back(apply_request(cur_req));
         req_taken = 1;
      end
   end

   // drive requests from the pending queue, with random gaps between them
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         req_taken = 0;
         if (req_gap > 0) begin
            req_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(1, 9) - 1;
               req_chan.valid <= 1'b0;
            end else begin
               cur_req = pending_reqs.pop_front();
               req_chan.operation       <= cur_req.op;
               req_chan.node_priority   <= cur_req.prio;
               req_chan.request_timeout <= cur_req.tmo;
               req_chan.request_tag     <= cur_req.tag;
               req_chan.time_now        <= cur_req.now;
               req_chan.valid           <= 1'b1;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // count down the long response hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left = HOLD_CYCLES;
      end
      rsp_hold = (hold_left > 0);
   end

   // drive response ready with random stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_chan.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(1, 9) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !rsp_hold;
      end
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      response_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual status %0h",
                     $time, rsp_chan.status);
         end else begin
            want = expected_rsps.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_chan.status));
            check_field("top_tag", 32'(want.tag), 32'(rsp_chan.top_tag));
            check_field("top_priority", 32'(want.prio), 32'(rsp_chan.top_priority));
            check_field("top_timeout", want.tmo, rsp_chan.top_timeout);
            check_field("entry_count", 32'(want.count), 32'(rsp_chan.entry_count));
         end
      end
   end

   // run limit
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // stimulus sequence
   initial begin : stimulus
      logic [6:0] settings [5];
      int spans [5];
      settings = '{7'd127, 7'd100, 7'd1, 7'd0, 7'd50};
      spans    = '{2500, 300, 60, 1200, 600};
      settings[3] = 7'($urandom_range(0, 127));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_default(7'd0);

      // empty queue: top, clean and the unused code
      add_item(OP_TOP, 7'd0, 32'd0, 16'd0, 32'd0);
      add_item(OP_CLEAN, 7'd0, 32'd0, 16'd0, 32'd0);
      add_item(OP_UNUSED, 7'd127, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      // out-of-range priority takes the default, then equal priorities
      add_item(OP_INSERT, 7'd127, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
      add_item(OP_INSERT, 7'd100, 32'd0, 16'h0000, 32'd0);
      add_item(OP_INSERT, 7'd0, 32'd1000, 16'h1234, 32'd0);
      add_item(OP_INSERT, 7'd100, 32'd500, 16'hA5A5, 32'd0);
      // timeout equal to now has not expired; one above does
      add_item(OP_TOP, 7'd0, 32'd0, 16'd0, 32'd0);
      add_item(OP_TOP, 7'd0, 32'd0, 16'd0, 32'd1);
      add_item(OP_CLEAN, 7'd0, 32'd0, 16'd0, 32'd1001);
      add_item(OP_TOP, 7'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
      // fill the queue and one insert beyond full
      for (int k = 0; k < 16; k++)
         add_item(OP_INSERT, 7'(k * 7), 32'(k * 100), 16'(k), 32'd0);
      add_item(OP_TOP, 7'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
      wait_drained();

      // random phases under several default settings
      for (int ph = 0; ph < 5; ph++) begin
         write_default(settings[ph]);
         sim_now = $urandom;
         if (ph == 4)
            quiet = 1;
         add_random_items(PHASE_ITEMS, spans[ph]);
         if (ph == 1)
            hold_request = 1;
         wait_drained();
      end

      if (expected_rsps.size() != 0) begin
         errors++;
         $display("%0t: responses missing, expected %0d more, actual 0",
                  $time, expected_rsps.size());
      end
      $display("covered %0d inserts (%0d refused full), %0d tops (%0d empty),",
               n_insert, n_full, n_top, n_empty);
      $display("%0d cleans, %0d unused codes, %0d default settings, %0d errors",
               n_clean, n_unused, n_settings, errors);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/prq_pkg.sv
rtl/prq_channels.sv
rtl/prq_ram.sv
rtl/prq_datapath.sv
rtl/prq_ctrl.sv
rtl/priority_request_queue_expiry_core.sv
verif/tb_priority_request_queue_expiry_core.sv
